// File: hdl/esh_pkg.sv
`timescale 1ns / 1ps
package esh_pkg;

	localparam int MAX_LAYERS  = 64;
	localparam int MAX_EXPERTS = 256;
	localparam int CNT_W       = 32;
	localparam int LAYER_W     = 6;
	localparam int EXP_W       = 8;
	localparam int ADDR_W      = LAYER_W + EXP_W;
	localparam int DEPTH       = MAX_LAYERS * MAX_EXPERTS;
	localparam int NL_W        = 7;
	localparam int NE_W        = 9;
	localparam int FRAC_W      = 17;
	localparam int SLOT_W      = 15;
	localparam int SUM_W       = 46;
	localparam int TOT_W       = 48;
	localparam int RATIO_W     = 17;
	localparam int REM_W       = SUM_W + 1;
	localparam int DIV_STEPS   = 17;
	localparam int DCNT_W      = 5;

	localparam logic [SUM_W-1:0]  SUM_MAX   = {SUM_W{1'b1}};
	localparam logic [TOT_W-1:0]  TOTAL_MAX = {TOT_W{1'b1}};
	localparam logic [CNT_W-1:0]  COUNT_MAX = {CNT_W{1'b1}};
	localparam logic [FRAC_W-1:0] FRAC_ONE  = 17'h10000;

	localparam logic [1:0] CMD_RECORD = 2'd0;
	localparam logic [1:0] CMD_LAYER  = 2'd1;
	localparam logic [1:0] CMD_ALL    = 2'd2;

	localparam logic CFG_LAYERS  = 1'b0;
	localparam logic CFG_EXPERTS = 1'b1;

	localparam logic [1:0] THR_ZERO = 2'd0;
	localparam logic [1:0] THR_MID  = 2'd1;
	localparam logic [1:0] THR_LO   = 2'd2;

	localparam logic [1:0] RES_REC  = 2'd0;
	localparam logic [1:0] RES_DROP = 2'd1;
	localparam logic [1:0] RES_COV  = 2'd2;
	localparam logic [1:0] RES_NONE = 2'd3;

	typedef struct packed {
		logic       load;
		logic       k_load;
		logic       scan_start;
		logic [1:0] thr_sel;
		logic       tot_save;
		logic       search_init;
		logic       search_upd;
		logic       mul;
		logic       top;
		logic       div_start;
		logic       rec_wr;
		logic       res_load;
		logic [1:0] res_kind;
	} esh_cmd_t;

	typedef struct packed {
		logic       clearing;
		logic [1:0] cmd;
		logic       rec_ok;
		logic       scan_busy;
		logic       full_k;
		logic       search_done;
		logic       div_busy;
	} esh_stat_t;

endpackage

// File: hdl/esh_ctrl.sv
`timescale 1ns / 1ps
module esh_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	input  esh_pkg::esh_stat_t st,
	output esh_pkg::esh_cmd_t  cmd
);
	import esh_pkg::*;

	localparam logic [3:0] S_CLEAR  = 4'd0;
	localparam logic [3:0] S_IDLE   = 4'd1;
	localparam logic [3:0] S_DECODE = 4'd2;
	localparam logic [3:0] S_REC_RD = 4'd3;
	localparam logic [3:0] S_REC_WR = 4'd4;
	localparam logic [3:0] S_TOT    = 4'd5;
	localparam logic [3:0] S_SRCH   = 4'd6;
	localparam logic [3:0] S_GE     = 4'd7;
	localparam logic [3:0] S_FIN    = 4'd8;
	localparam logic [3:0] S_MUL    = 4'd9;
	localparam logic [3:0] S_TOP    = 4'd10;
	localparam logic [3:0] S_DIV_GO = 4'd11;
	localparam logic [3:0] S_DIV    = 4'd12;

	logic [3:0] state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		unique case (state_q)
			S_CLEAR: begin
				if (!st.clearing) state_d = S_IDLE;
			end
			S_IDLE: begin
				if (start) begin
					cmd.load = 1'b1;
					state_d  = S_DECODE;
				end
			end
			S_DECODE: begin
				priority if (st.cmd == CMD_RECORD) begin
					if (st.rec_ok) begin
						state_d = S_REC_RD;
					end else begin
						cmd.res_load = 1'b1;
						cmd.res_kind = RES_DROP;
						state_d      = S_IDLE;
					end
				end else if (st.cmd == CMD_LAYER || st.cmd == CMD_ALL) begin
					cmd.k_load     = 1'b1;
					cmd.scan_start = 1'b1;
					cmd.thr_sel    = THR_ZERO;
					state_d        = S_TOT;
				end else begin
					cmd.res_load = 1'b1;
					cmd.res_kind = RES_NONE;
					state_d      = S_IDLE;
				end
			end
			S_REC_RD: state_d = S_REC_WR;
			S_REC_WR: begin
				cmd.rec_wr   = 1'b1;
				cmd.res_load = 1'b1;
				cmd.res_kind = RES_REC;
				state_d      = S_IDLE;
			end
			S_TOT: begin
				if (!st.scan_busy) begin
					cmd.tot_save    = 1'b1;
					cmd.search_init = 1'b1;
					state_d         = st.full_k ? S_TOP : S_SRCH;
				end
			end
			S_SRCH: begin
				cmd.scan_start = 1'b1;
				if (st.search_done) begin
					cmd.thr_sel = THR_LO;
					state_d     = S_FIN;
				end else begin
					cmd.thr_sel = THR_MID;
					state_d     = S_GE;
				end
			end
			S_GE: begin
				if (!st.scan_busy) begin
					cmd.search_upd = 1'b1;
					state_d        = S_SRCH;
				end
			end
			S_FIN: begin
				if (!st.scan_busy) state_d = S_MUL;
			end
			S_MUL: begin
				cmd.mul = 1'b1;
				state_d = S_TOP;
			end
			S_TOP: begin
				cmd.top = 1'b1;
				state_d = S_DIV_GO;
			end
			S_DIV_GO: begin
				cmd.div_start = 1'b1;
				state_d       = S_DIV;
			end
			S_DIV: begin
				if (!st.div_busy) begin
					cmd.res_load = 1'b1;
					cmd.res_kind = RES_COV;
					state_d      = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	assign busy = (state_q != S_IDLE);

	a_no_accept_clearing: assert property (@(posedge clk) disable iff (!arst_n)
		st.clearing |-> busy)
		else $error("item accepted during table clear");
	a_res_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.res_load |=> state_q == S_IDLE)
		else $error("result issued without return to idle");
	a_scan_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.scan_start |-> !st.scan_busy)
		else $error("scan restarted while running");

endmodule

// File: hdl/esh_datapath.sv
`timescale 1ns / 1ps
module esh_datapath (
	input  logic                          clk,
	input  logic                          arst_n,
	input  esh_pkg::esh_cmd_t             cmd,
	output esh_pkg::esh_stat_t            st,
	input  logic [1:0]                    command,
	input  logic [esh_pkg::LAYER_W-1:0]   layer,
	input  logic [esh_pkg::EXP_W-1:0]     expert,
	input  logic [esh_pkg::FRAC_W-1:0]    fraction,
	input  logic                          cfg_valid,
	input  logic                          cfg_index,
	input  logic [esh_pkg::NE_W-1:0]      cfg_data,
	output logic                          done,
	output logic                          status,
	output logic [esh_pkg::CNT_W-1:0]     new_count,
	output logic [esh_pkg::SUM_W-1:0]     top_sum,
	output logic [esh_pkg::SUM_W-1:0]     scope_total,
	output logic [esh_pkg::SLOT_W-1:0]    top_slots,
	output logic [esh_pkg::RATIO_W-1:0]   coverage_ratio,
	output logic [esh_pkg::TOT_W-1:0]     selection_total
);
	import esh_pkg::*;

	logic [CNT_W-1:0]   mem [DEPTH];
	logic [CNT_W-1:0]   rd_data_q;
	logic [ADDR_W-1:0]  raddr, waddr;
	logic [CNT_W-1:0]   wdata;
	logic               we;

	logic               clearing_q;
	logic [ADDR_W-1:0]  clr_addr_q;
	logic [NL_W-1:0]    layers_q;
	logic [NE_W-1:0]    experts_q;
	logic [TOT_W-1:0]   total_q, total_next;

	logic [1:0]         cmd_q;
	logic [LAYER_W-1:0] layer_q;
	logic [EXP_W-1:0]   expert_q;
	logic [FRAC_W-1:0]  frac_q;
	logic [SLOT_W-1:0]  slots_q, k_q;

	logic [NL_W-1:0]    nl;
	logic [NE_W-1:0]    ne;
	logic               rec_ok, empty;
	logic [NL_W+NE_W-1:0] nl_ne;
	logic [FRAC_W-1:0]  frac_c;
	logic [SLOT_W+FRAC_W-1:0] k_prod;
	logic [15:0]        k_raw;

	logic               issuing_q, rd_valid_s1;
	logic [LAYER_W-1:0] scan_r_q, last_r_q;
	logic [EXP_W-1:0]   scan_e_q;
	logic [CNT_W-1:0]   thr_q, thr_d;
	logic [SLOT_W-1:0]  ge_q, gt_q;
	logic [SUM_W-1:0]   sum_q;
	logic [SUM_W:0]     sum_add;

	logic [CNT_W-1:0]   lo_q, hi_q, mid;
	logic [CNT_W:0]     span;
	logic [SUM_W-1:0]   tot_q, top_q;
	logic [REM_W-1:0]   prod_q;
	logic [SUM_W-1:0]   prod_c;
	logic [SUM_W:0]     top_add;
	logic [SUM_W-1:0]   top_c;

	logic [REM_W-1:0]   rem_q, rem_sub;
	logic [RATIO_W-1:0] quo_q;
	logic [DCNT_W-1:0]  div_cnt_q;
	logic               rem_ge;
	logic [CNT_W-1:0]   rec_new;

	// effective scope limits
	assign nl = (layers_q > NL_W'(MAX_LAYERS)) ? NL_W'(MAX_LAYERS) : layers_q;
	assign ne = (experts_q > NE_W'(MAX_EXPERTS)) ? NE_W'(MAX_EXPERTS) : experts_q;
	assign rec_ok = ({1'b0, layer_q} < nl) && ({1'b0, expert_q} < ne);
	assign empty = (cmd_q == CMD_LAYER) ? (({1'b0, layer_q} >= nl) || ne == '0)
	                                     : (nl == '0 || ne == '0);
	assign nl_ne  = nl * ne;
	assign frac_c = (frac_q > FRAC_ONE) ? FRAC_ONE : frac_q;
	assign k_prod = slots_q * frac_c;
	assign k_raw  = k_prod[SLOT_W+FRAC_W-1:16];

	assign rec_new = (rd_data_q == COUNT_MAX) ? rd_data_q : rd_data_q + 1'b1;
	assign total_next = (total_q == TOTAL_MAX) ? total_q : total_q + 1'b1;

	assign raddr = issuing_q ? {scan_r_q, scan_e_q} : {layer_q, expert_q};
	assign we    = clearing_q | cmd.rec_wr;
	assign waddr = clearing_q ? clr_addr_q : {layer_q, expert_q};
	assign wdata = clearing_q ? '0 : rec_new;

	always_ff @(posedge clk) begin
		if (we) mem[waddr] <= wdata;
		rd_data_q <= mem[raddr];
	end

	assign span = {1'b0, hi_q} - {1'b0, lo_q} + 1'b1;
	assign mid  = lo_q + span[CNT_W:1];

	always_comb begin
		unique case (cmd.thr_sel)
			THR_MID: thr_d = mid;
			THR_LO:  thr_d = lo_q;
			default: thr_d = '0;
		endcase
	end

	assign sum_add = {1'b0, sum_q} + (SUM_W+1)'(rd_data_q);
	assign prod_c  = (prod_q > REM_W'(SUM_MAX)) ? SUM_MAX : prod_q[SUM_W-1:0];
	assign top_add = {1'b0, sum_q} + {1'b0, prod_c};
	assign top_c   = top_add[SUM_W] ? SUM_MAX : top_add[SUM_W-1:0];

	assign rem_ge  = rem_q >= REM_W'(tot_q);
	assign rem_sub = rem_ge ? rem_q - REM_W'(tot_q) : rem_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clearing_q  <= 1'b1;
			clr_addr_q  <= '0;
			layers_q    <= NL_W'(MAX_LAYERS);
			experts_q   <= NE_W'(MAX_EXPERTS);
			total_q     <= '0;
			issuing_q   <= 1'b0;
			rd_valid_s1 <= 1'b0;
			div_cnt_q   <= '0;
			done        <= 1'b0;
		end else begin
			if (clearing_q) begin
				clr_addr_q <= clr_addr_q + 1'b1;
				if (&clr_addr_q) clearing_q <= 1'b0;
			end
			if (cfg_valid) begin
				unique case (cfg_index)
					CFG_LAYERS:  layers_q  <= cfg_data[NL_W-1:0];
					CFG_EXPERTS: experts_q <= cfg_data;
					default: ;
				endcase
			end
			if (cmd.rec_wr) total_q <= total_next;
			rd_valid_s1 <= issuing_q;
			if (cmd.scan_start) begin
				issuing_q <= !empty;
			end else if (issuing_q && {1'b0, scan_e_q} == ne - 1'b1 &&
			             scan_r_q == last_r_q) begin
				issuing_q <= 1'b0;
			end
			if (cmd.div_start) begin
				div_cnt_q <= DCNT_W'(DIV_STEPS);
			end else if (div_cnt_q != '0) begin
				div_cnt_q <= div_cnt_q - 1'b1;
			end
			done <= cmd.res_load;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			cmd_q    <= command;
			layer_q  <= layer;
			expert_q <= expert;
			frac_q   <= fraction;
			slots_q  <= (command == CMD_LAYER) ? SLOT_W'(ne) : SLOT_W'(nl_ne);
		end
		if (cmd.k_load) k_q <= (k_raw == '0) ? SLOT_W'(1) : k_raw[SLOT_W-1:0];

		// scan address walk, row by row
		if (cmd.scan_start) begin
			scan_r_q <= (cmd_q == CMD_LAYER) ? layer_q : '0;
			last_r_q <= (cmd_q == CMD_LAYER) ? layer_q : LAYER_W'(nl - 1'b1);
			scan_e_q <= '0;
			thr_q    <= thr_d;
		end else if (issuing_q) begin
			if ({1'b0, scan_e_q} == ne - 1'b1) begin
				scan_e_q <= '0;
				scan_r_q <= scan_r_q + 1'b1;
			end else begin
				scan_e_q <= scan_e_q + 1'b1;
			end
		end

		if (cmd.scan_start) begin
			ge_q  <= '0;
			gt_q  <= '0;
			sum_q <= '0;
		end else if (rd_valid_s1) begin
			if (rd_data_q >= thr_q) ge_q <= ge_q + 1'b1;
			if (rd_data_q > thr_q) begin
				gt_q  <= gt_q + 1'b1;
				sum_q <= sum_add[SUM_W] ? SUM_MAX : sum_add[SUM_W-1:0];
			end
		end

		if (cmd.tot_save) tot_q <= sum_q;
		if (cmd.search_init) begin
			lo_q <= '0;
			hi_q <= COUNT_MAX;
		end else if (cmd.search_upd) begin
			if (ge_q >= k_q) lo_q <= thr_q;
			else hi_q <= thr_q - 1'b1;
		end
		if (cmd.mul) prod_q <= (k_q - gt_q) * lo_q;
		if (cmd.top) begin
			if (st.full_k) top_q <= tot_q;
			else top_q <= (top_c > tot_q) ? tot_q : top_c;
		end

		// restoring division, one quotient bit a cycle
		if (cmd.div_start) begin
			rem_q <= REM_W'(top_q);
			quo_q <= '0;
		end else if (div_cnt_q != '0) begin
			quo_q <= {quo_q[RATIO_W-2:0], rem_ge};
			rem_q <= {rem_sub[REM_W-2:0], 1'b0};
		end

		if (cmd.res_load) begin
			unique case (cmd.res_kind)
				RES_REC: begin
					status          <= 1'b0;
					new_count       <= rec_new;
					top_sum         <= '0;
					scope_total     <= '0;
					top_slots       <= '0;
					coverage_ratio  <= '0;
					selection_total <= total_next;
				end
				RES_COV: begin
					status          <= 1'b0;
					new_count       <= '0;
					top_sum         <= top_q;
					scope_total     <= tot_q;
					top_slots       <= k_q;
					coverage_ratio  <= (tot_q == '0) ? '0 : quo_q;
					selection_total <= total_q;
				end
				default: begin
					// dropped record or unknown command
					status          <= (cmd.res_kind == RES_DROP);
					new_count       <= '0;
					top_sum         <= '0;
					scope_total     <= '0;
					top_slots       <= '0;
					coverage_ratio  <= '0;
					selection_total <= total_q;
				end
			endcase
		end
	end

	always_comb begin
		st             = '0;
		st.clearing    = clearing_q;
		st.cmd         = cmd_q;
		st.rec_ok      = rec_ok;
		st.scan_busy   = issuing_q | rd_valid_s1;
		st.full_k      = (k_q >= slots_q) || empty;
		st.search_done = (lo_q == hi_q);
		st.div_busy    = (div_cnt_q != '0);
	end

	a_ratio_range: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> coverage_ratio <= RATIO_W'(FRAC_ONE))
		else $error("coverage ratio above one");
	a_top_le_tot: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.top |=> top_q <= tot_q)
		else $error("top sum exceeds scope total");
	a_no_scan_write: assert property (@(posedge clk) disable iff (!arst_n)
		issuing_q |-> !cmd.rec_wr && !clearing_q)
		else $error("table written during scan");

endmodule

// File: hdl/expert_selection_histogram.sv
`timescale 1ns / 1ps
// channel   direction  transaction                      signals
// item      in         start && !busy                   command layer expert fraction
// result    out        done, one cycle                  status new_count top_sum scope_total
//                                                       top_slots coverage_ratio selection_total
// config    in         cfg_valid && cfg_ready           cfg_index cfg_data
//
// after reset the count table is cleared one entry a cycle, all 16384 entries, with busy high
// a record steps through decode, table read, read-modify-write, then idle
// a coverage query walks the scope once per step: one total pass, then, unless the top slots
// take in all of the scope, up to 32 threshold passes of a binary search and a final pass,
// each over the single table read port, then a restoring divide; invalid records and command 3
// return from decode; the result appears in the cycle after its last step and cannot be held off
module expert_selection_histogram (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	output logic                          busy,
	input  logic [1:0]                    command,
	input  logic [esh_pkg::LAYER_W-1:0]   layer,
	input  logic [esh_pkg::EXP_W-1:0]     expert,
	input  logic [esh_pkg::FRAC_W-1:0]    fraction,
	output logic                          done,
	output logic                          status,
	output logic [esh_pkg::CNT_W-1:0]     new_count,
	output logic [esh_pkg::SUM_W-1:0]     top_sum,
	output logic [esh_pkg::SUM_W-1:0]     scope_total,
	output logic [esh_pkg::SLOT_W-1:0]    top_slots,
	output logic [esh_pkg::RATIO_W-1:0]   coverage_ratio,
	output logic [esh_pkg::TOT_W-1:0]     selection_total,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic                          cfg_index,
	input  logic [esh_pkg::NE_W-1:0]      cfg_data
);
	import esh_pkg::*;

	esh_cmd_t  cmd;
	esh_stat_t st;

	assign cfg_ready = 1'b1;

	esh_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.st     (st),
		.cmd    (cmd)
	);

	esh_datapath u_dp (
		.clk             (clk),
		.arst_n          (arst_n),
		.cmd             (cmd),
		.st              (st),
		.command         (command),
		.layer           (layer),
		.expert          (expert),
		.fraction        (fraction),
		.cfg_valid       (cfg_valid),
		.cfg_index       (cfg_index),
		.cfg_data        (cfg_data),
		.done            (done),
		.status          (status),
		.new_count       (new_count),
		.top_sum         (top_sum),
		.scope_total     (scope_total),
		.top_slots       (top_slots),
		.coverage_ratio  (coverage_ratio),
		.selection_total (selection_total)
	);

endmodule

// File: test/esh_checker.sv
`timescale 1ns / 1ps
module esh_checker (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic                          busy,
	input  logic [1:0]                    command,
	input  logic [esh_pkg::LAYER_W-1:0]   layer,
	input  logic [esh_pkg::EXP_W-1:0]     expert,
	input  logic [esh_pkg::FRAC_W-1:0]    fraction,
	input  logic                          done,
	input  logic                          status,
	input  logic [esh_pkg::CNT_W-1:0]     new_count,
	input  logic [esh_pkg::SUM_W-1:0]     top_sum,
	input  logic [esh_pkg::SUM_W-1:0]     scope_total,
	input  logic [esh_pkg::SLOT_W-1:0]    top_slots,
	input  logic [esh_pkg::RATIO_W-1:0]   coverage_ratio,
	input  logic [esh_pkg::TOT_W-1:0]     selection_total,
	input  logic                          cfg_valid,
	input  logic                          cfg_ready,
	input  logic                          cfg_index,
	input  logic [esh_pkg::NE_W-1:0]      cfg_data,
	output int                            errors,
	output int                            pending
);
	import esh_pkg::*;

	typedef struct {
		logic               status;
		logic [CNT_W-1:0]   new_count;
		logic [SUM_W-1:0]   top_sum;
		logic [SUM_W-1:0]   scope_total;
		logic [SLOT_W-1:0]  top_slots;
		logic [RATIO_W-1:0] ratio;
		logic [TOT_W-1:0]   sel_total;
	} outcome_t;

	logic [CNT_W-1:0] count_store [DEPTH];
	logic [TOT_W-1:0] selections;
	logic [NL_W-1:0]  layers_cfg;
	logic [NE_W-1:0]  experts_cfg;
	outcome_t         outcome_q[$];

	assign pending = outcome_q.size();

	task automatic report(string what, longint unsigned got, longint unsigned want);
		$display("mismatch %s: got %0h expected %0h", what, got, want);
		errors++;
	endtask

	function automatic outcome_t predict_outcome(logic [1:0] cmd, int unsigned lyr,
			int unsigned exp_i, int unsigned frac);
		outcome_t o;
		int unsigned nl, ne, r0, r1, idx, lim;
		longint unsigned slots, k, tot, top;
		int unsigned vals[$];
		nl = (layers_cfg < MAX_LAYERS) ? layers_cfg : MAX_LAYERS;
		ne = (experts_cfg < MAX_EXPERTS) ? experts_cfg : MAX_EXPERTS;
		o = '{default: '0};
		if (cmd == CMD_RECORD) begin
			if (lyr >= nl || exp_i >= ne) begin
				o.status = 1'b1;
			end else begin
				idx = lyr * MAX_EXPERTS + exp_i;
				if (count_store[idx] != COUNT_MAX) count_store[idx]++;
				if (selections != TOTAL_MAX) selections++;
				o.new_count = count_store[idx];
			end
		end else if (cmd == CMD_LAYER || cmd == CMD_ALL) begin
			r0 = 0;
			r1 = 0;
			if (cmd == CMD_LAYER) begin
				if (lyr < nl) begin
					r0 = lyr;
					r1 = lyr + 1;
				end
				slots = ne;
			end else begin
				r1 = nl;
				slots = nl * ne;
			end
			if (frac > FRAC_ONE) frac = FRAC_ONE;
			k = (slots * frac) >> 16;
			if (k < 1) k = 1;
			for (int r = r0; r < r1; r++)
				for (int e = 0; e < ne; e++)
					vals.insert(vals.size(), count_store[r * MAX_EXPERTS + e]);
			vals.rsort();
			tot = 0;
			top = 0;
			lim = (k < vals.size()) ? k : vals.size();
			foreach (vals[i]) begin
				tot += vals[i];
				if (i < lim) top += vals[i];
			end
			// 32-bit counts over at most 16384 slots never exceed the sum width
			o.top_sum = SUM_W'(top);
			o.scope_total = SUM_W'(tot);
			o.top_slots = SLOT_W'(k);
			o.ratio = (tot != 0) ? RATIO_W'((top << 16) / tot) : '0;
		end
		o.sel_total = selections;
		return o;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		outcome_t want;
		if (!arst_n) begin
			foreach (count_store[i]) count_store[i] = '0;
			selections = '0;
			layers_cfg = 7'd64;
			experts_cfg = 9'd256;
			errors = 0;
			outcome_q.delete();
		end else begin
			if (done) begin
				if (outcome_q.size() == 0) begin
					report("unexpected result", 0, 0);
				end else begin
					want = outcome_q.pop_front();
					if (status !== want.status) report("status", status, want.status);
					if (new_count !== want.new_count)
						report("new_count", new_count, want.new_count);
					if (top_sum !== want.top_sum) report("top_sum", top_sum, want.top_sum);
					if (scope_total !== want.scope_total)
						report("scope_total", scope_total, want.scope_total);
					if (top_slots !== want.top_slots)
						report("top_slots", top_slots, want.top_slots);
					if (coverage_ratio !== want.ratio)
						report("coverage_ratio", coverage_ratio, want.ratio);
					if (selection_total !== want.sel_total)
						report("selection_total", selection_total, want.sel_total);
				end
			end
			if (start && !busy)
				outcome_q.insert(outcome_q.size(),
					predict_outcome(command, layer, expert, fraction));
			if (cfg_valid && cfg_ready) begin
				if (cfg_index == CFG_LAYERS) layers_cfg = cfg_data[NL_W-1:0];
				else experts_cfg = cfg_data;
			end
		end
	end
endmodule

// File: test/tb_expert_selection_histogram.sv
`timescale 1ns / 1ps
module tb_expert_selection_histogram;
	import esh_pkg::*;

	localparam int CYCLE_LIMIT = 4000000;
	// command code with no effect
	localparam logic [1:0] CMD_NOP = 2'd3;

	logic                clk, arst_n;
	logic                start, busy, done;
	logic [1:0]          command;
	logic [LAYER_W-1:0]  layer;
	logic [EXP_W-1:0]    expert;
	logic [FRAC_W-1:0]   fraction;
	logic                status;
	logic [CNT_W-1:0]    new_count;
	logic [SUM_W-1:0]    top_sum, scope_total;
	logic [SLOT_W-1:0]   top_slots;
	logic [RATIO_W-1:0]  coverage_ratio;
	logic [TOT_W-1:0]    selection_total;
	logic                cfg_valid, cfg_ready, cfg_index;
	logic [NE_W-1:0]     cfg_data;
	int                  errors, pending;
	int                  cycles;
	bit                  no_idle;
	int                  nl_eff, ne_eff;

	expert_selection_histogram dut (.*);

	esh_checker chk (.*);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		cycles = 0;
		forever begin
			@(posedge clk);
			cycles++;
			if (cycles > CYCLE_LIMIT) begin
				$display("FAIL");
				$finish;
			end
		end
	end

	task automatic issue(logic [1:0] cmd, int unsigned lyr, int unsigned exp_i,
			int unsigned frac);
		int gap;
		gap = no_idle ? 0 : $urandom_range(0, 15);
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start <= 1'b1;
		command <= cmd;
		layer <= LAYER_W'(lyr);
		expert <= EXP_W'(exp_i);
		fraction <= FRAC_W'(frac);
		do @(posedge clk); while (busy);
	endtask

	task automatic settle();
		start <= 1'b0;
		while (pending != 0) @(posedge clk);
		repeat (8) @(posedge clk);
		while (busy) @(posedge clk);
	endtask

	task automatic cfg_write(logic idx, int unsigned data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= NE_W'(data);
		do @(posedge clk); while (!cfg_ready);
	endtask

	task automatic set_scope(int unsigned lyr_data, int unsigned exp_data);
		settle();
		cfg_write(CFG_LAYERS, lyr_data);
		cfg_write(CFG_EXPERTS, exp_data);
		cfg_valid <= 1'b0;
		nl_eff = ((lyr_data & 'h7f) < MAX_LAYERS) ? (lyr_data & 'h7f) : MAX_LAYERS;
		ne_eff = (exp_data < MAX_EXPERTS) ? exp_data : MAX_EXPERTS;
	endtask

	function automatic int unsigned pick_fraction();
		case ($urandom_range(0, 3))
			0: return $urandom_range(0, 131071);
			1: return FRAC_ONE;
			default: return $urandom_range(0, 65536);
		endcase
	endfunction

	initial begin
		int unsigned lv, ev, r;
		start = 1'b0;
		command = CMD_RECORD;
		layer = '0;
		expert = '0;
		fraction = '0;
		cfg_valid = 1'b0;
		cfg_index = CFG_LAYERS;
		cfg_data = '0;
		no_idle = 1'b0;
		arst_n = 1'b0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;

		// reset sizes: 64 layers, 256 experts
		issue(CMD_RECORD, 63, 255, 131071);
		issue(CMD_RECORD, 63, 255, 0);
		issue(CMD_RECORD, 0, 0, 0);
		issue(CMD_RECORD, 0, 0, 0);
		issue(CMD_RECORD, 0, 0, 0);
		issue(CMD_RECORD, 5, 17, 0);
		issue(CMD_NOP, 63, 255, 131071);
		issue(CMD_LAYER, 0, 0, 0);
		issue(CMD_LAYER, 0, 0, FRAC_ONE);
		issue(CMD_LAYER, 63, 0, 131071);
		issue(CMD_LAYER, 7, 0, 32768);
		issue(CMD_ALL, 0, 0, 32768);
		// no valid layer: everything is out of scope
		set_scope(0, 256);
		issue(CMD_RECORD, 0, 0, 0);
		issue(CMD_ALL, 0, 0, FRAC_ONE);
		issue(CMD_LAYER, 0, 0, FRAC_ONE);
		// register values above the table size
		set_scope('h1ff, 'h1ff);
		issue(CMD_RECORD, 63, 255, 0);
		set_scope(2, 4);
		issue(CMD_RECORD, 1, 3, 0);
		issue(CMD_RECORD, 2, 0, 0);
		issue(CMD_RECORD, 1, 4, 0);
		issue(CMD_LAYER, 1, 0, 16384);
		issue(CMD_ALL, 0, 0, 40000);

		for (int phase = 0; phase < 12; phase++) begin
			if (phase == 3) begin
				lv = 1;
				ev = 300;
			end else if (phase == 6) begin
				lv = 100;
				ev = 1;
			end else begin
				lv = $urandom_range(1, 5);
				ev = $urandom_range(1, 10);
			end
			// unused upper bits of the layer register
			set_scope(lv | ($urandom_range(0, 3) << 7), ev);
			no_idle = ($urandom_range(0, 3) == 0);
			for (int i = 0; i < 120; i++) begin
				r = $urandom_range(0, 99);
				if (r < 78)
					issue(CMD_RECORD, $urandom_range(0, nl_eff - 1),
						$urandom_range(0, ne_eff - 1), $urandom_range(0, 131071));
				else if (r < 85)
					issue(CMD_RECORD, $urandom_range(0, 63), $urandom_range(0, 255),
						$urandom_range(0, 131071));
				else if (r < 93)
					issue(CMD_LAYER, ($urandom_range(0, 4) == 0) ? $urandom_range(0, 63)
						: $urandom_range(0, nl_eff), $urandom_range(0, 255), pick_fraction());
				else if (r < 98)
					issue(CMD_ALL, $urandom_range(0, 63), $urandom_range(0, 255),
						pick_fraction());
				else
					issue(CMD_NOP, $urandom_range(0, 63), $urandom_range(0, 255),
						$urandom_range(0, 131071));
			end
		end

		start <= 1'b0;
		while (pending != 0) @(posedge clk);
		repeat (20) @(posedge clk);
		if (errors == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end
endmodule
